// ===== sv/set_assoc_cache_tag_lru_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the set-associative tag/LRU block
// Shared concurrent-assertion shorthands, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LRU_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LRU_TOP_MACROS_SVH

// same-cycle implication
`define SACTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SACTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sactl_pkg.sv =====
// ---------------------------------------------------------------------------
// sactl_pkg
// Geometry, row layout and register codes of the set-associative tag/LRU block.
// ---------------------------------------------------------------------------
package sactl_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int SETS        = 16;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 8;

  localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
  localparam int SET_BITS  = $clog2(SETS);
  localparam int WAY_BITS  = $clog2(WAYS);
  localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int LINES     = SETS * WAYS;
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 32;
  localparam int COST_W    = 8;

  // configuration register indexes
  localparam logic CFG_HIT_COST     = 1'b0;
  localparam logic CFG_MISS_PENALTY = 1'b1;

  localparam logic [COST_W-1:0] HIT_COST_RST     = 8'd1;
  localparam logic [COST_W-1:0] MISS_PENALTY_RST = 8'd100;

  // one way of a set row in the tag memory
  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [STAMP_W-1:0]  stamp;
  } way_ent_t;

  typedef way_ent_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // lookup outcome handed from the way selector to the top
  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way;
  } sel_t;

endpackage

// ===== sv/sactl_in_if.sv =====
// ---------------------------------------------------------------------------
// sactl_in_if
// Access channel: one byte address per word, valid/ready handshake.
// ---------------------------------------------------------------------------
interface sactl_in_if;
  logic                            valid;
  logic                            ready;
  logic [sactl_pkg::ADDR_BITS-1:0] byte_address;

  modport source (output valid, output byte_address, input ready);
  modport sink   (input valid, input byte_address, output ready);
endinterface

// ===== sv/sactl_out_if.sv =====
// ---------------------------------------------------------------------------
// sactl_out_if
// Result channel: hit, way, set, tag and running cycle total per word.
// ---------------------------------------------------------------------------
interface sactl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [1:0]                     way_used;
  logic [3:0]                     set_index;
  logic [24:0]                    line_tag;
  logic [sactl_pkg::CNT_W-1:0]    cycles_so_far;

  modport source (output valid, output hit, output way_used, output set_index,
                  output line_tag, output cycles_so_far, input ready);
  modport sink   (input valid, input hit, input way_used, input set_index,
                  input line_tag, input cycles_so_far, output ready);
endinterface

// ===== sv/sactl_ram.sv =====
// ---------------------------------------------------------------------------
// sactl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sactl_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/sactl_way_sel.sv =====
// ---------------------------------------------------------------------------
// sactl_way_sel
// Tag compare across the ways of one set and LRU victim choice.
// ---------------------------------------------------------------------------
module sactl_way_sel (
  input  sactl_pkg::row_t                    row,
  input  logic [sactl_pkg::WAYS-1:0]         valid,
  input  logic [sactl_pkg::TAG_BITS-1:0]     tag,
  output sactl_pkg::sel_t                    sel
);
  import sactl_pkg::*;

  logic                hit;
  logic [WAY_BITS-1:0] hit_way;
  logic                have_inv;
  logic [WAY_BITS-1:0] inv_way;
  logic [WAY_BITS-1:0] lru_way;
  logic [STAMP_W-1:0]  lru_stamp;

  // find the lowest valid way holding the tag
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid[w] && (row[w].tag == tag)) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
    end
  end

  // first invalid way, else oldest stamp with the lowest way on ties
  always_comb begin
    have_inv  = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    lru_stamp = row[0].stamp;
    for (int w = 0; w < WAYS; w++) begin
      if (!have_inv && !valid[w]) begin
        have_inv = 1'b1;
        inv_way  = WAY_BITS'(w);
      end
      if (row[w].stamp < lru_stamp) begin
        lru_stamp = row[w].stamp;
        lru_way   = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    sel.hit = hit;
    priority if (hit) begin
      sel.way = hit_way;
    end else if (have_inv) begin
      sel.way = inv_way;
    end else begin
      sel.way = lru_way;
    end
  end

endmodule

// ===== sv/set_assoc_cache_tag_lru_top.sv =====
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_lru_top
// 16-set, 4-way tag array with true LRU replacement and a saturating
// access cycle total.
//
//   channel  | dir | handshake          | word
//   ---------+-----+--------------------+------------------------------------
//   in_ch    | in  | valid/ready        | byte_address
//   out_ch   | out | valid/ready        | hit, way_used, set_index,
//            |     |                    | line_tag, cycles_so_far
//   cfg_*    | in  | cfg_we, no wait    | cfg_index, cfg_wdata
//
// An access reads the set row from the tag/stamp RAM, then compares,
// picks the way and writes the row back.
// A word waits in the output register; the next access is taken while it
// waits but holds in its compare cycle until the register frees.
// Reset clears the valid bits at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module set_assoc_cache_tag_lru_top (
  input  logic                          clk,
  input  logic                          rst_n,
  sactl_in_if.sink                      in_ch,
  sactl_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sactl_pkg::COST_W-1:0]  cfg_wdata
);
  import sactl_pkg::*;

`include "set_assoc_cache_tag_lru_top_macros.svh"

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic                      state_r, state_nxt;
  logic [ADDR_BITS-1:0]      addr_r;
  logic [SET_BITS-1:0]       set_r;
  logic [TAG_BITS-1:0]       tag_r;
  logic [SET_BITS-1:0]       in_set;
  logic [SET_BITS-1:0]       rd_set;
  logic [LINES-1:0]          valid_r;
  logic [WAYS-1:0]           row_valid;
  logic [STAMP_W-1:0]        aclk_r;
  logic [CNT_W-1:0]          cyc_r, cyc_nxt;
  logic [COST_W-1:0]         hit_cost_r;
  logic [COST_W-1:0]         miss_pen_r;
  logic [CNT_W+1:0]          sum_hit;
  logic [CNT_W+1:0]          sum_miss;
  logic [ROW_W-1:0]          rd_data;
  row_t                      rd_row;
  row_t                      wr_row;
  sel_t                      sel;
  logic                      in_acc;
  logic                      out_free;
  logic                      commit;
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic [WAY_BITS-1:0]       out_way_r;
  logic [SET_BITS-1:0]       out_set_r;
  logic [TAG_BITS-1:0]       out_tag_r;

  // split the held address
  assign set_r  = addr_r[OFF_BITS +: SET_BITS];
  assign tag_r  = addr_r[ADDR_BITS-1 -: TAG_BITS];
  assign in_set = in_ch.byte_address[OFF_BITS +: SET_BITS];

  // handshake and sequencing
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign commit      = (state_r == S_LOOK) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_LOOK;
      S_LOOK: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // read the incoming set while idle, keep rereading the held set otherwise
  assign rd_set = (state_r == S_IDLE) ? in_set : set_r;

  sactl_ram #(
    .DATA_W (ROW_W),
    .DEPTH  (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (set_r),
    .wdata (wr_row),
    .raddr (rd_set),
    .rdata (rd_data)
  );

  assign rd_row    = row_t'(rd_data);
  assign row_valid = valid_r[{set_r, {WAY_BITS{1'b0}}} +: WAYS];

  sactl_way_sel u_way_sel (
    .row   (rd_row),
    .valid (row_valid),
    .tag   (tag_r),
    .sel   (sel)
  );

  // stamp the chosen way, fill its tag on a miss
  always_comb begin
    wr_row                = rd_row;
    wr_row[sel.way].stamp = aclk_r;
    if (!sel.hit) begin
      wr_row[sel.way].tag = tag_r;
    end
  end

  // running cycle total, saturating
  assign sum_hit  = {2'b00, cyc_r} + {{(CNT_W+2-COST_W){1'b0}}, hit_cost_r};
  assign sum_miss = sum_hit + {{(CNT_W+2-COST_W){1'b0}}, miss_pen_r};

  always_comb begin
    if (sel.hit) begin
      cyc_nxt = (sum_hit[CNT_W+1:CNT_W] != 2'b00) ? {CNT_W{1'b1}} : sum_hit[CNT_W-1:0];
    end else begin
      cyc_nxt = (sum_miss[CNT_W+1:CNT_W] != 2'b00) ? {CNT_W{1'b1}} : sum_miss[CNT_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      aclk_r      <= '0;
      cyc_r       <= '0;
      hit_cost_r  <= HIT_COST_RST;
      miss_pen_r  <= MISS_PENALTY_RST;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r                <= 1'b1;
        valid_r[{set_r, sel.way}]  <= 1'b1;
        aclk_r                     <= aclk_r + STAMP_W'(1);
        cyc_r                      <= cyc_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HIT_COST:     hit_cost_r <= cfg_wdata;
          CFG_MISS_PENALTY: miss_pen_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload: held address and output word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r <= in_ch.byte_address;
    end
    if (commit) begin
      out_hit_r <= sel.hit;
      out_way_r <= sel.way;
      out_set_r <= set_r;
      out_tag_r <= tag_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.way_used      = out_way_r;
  assign out_ch.set_index     = out_set_r;
  assign out_ch.line_tag      = out_tag_r;
  assign out_ch.cycles_so_far = cyc_r;

  // checks
  `SACTL_ASSERT_NEXT(a_fill_valid, commit, valid_r[$past({set_r, sel.way})], "filled way not valid")
  `SACTL_ASSERT_NEXT(a_clock_step, commit, aclk_r == $past(aclk_r) + STAMP_W'(1), "access clock did not step")
  `SACTL_ASSERT_NEXT(a_cnt_mono, 1'b1, cyc_r >= $past(cyc_r), "cycle total went down")
  `SACTL_ASSERT_NEXT(a_word_out, commit, out_ch.valid && (out_ch.hit == $past(sel.hit)), "result word lost")
  `SACTL_ASSERT_NOW(a_hit_valid, commit && sel.hit, row_valid[sel.way], "hit on invalid way")

endmodule
